// ===== design/sss_pkg.sv =====
// Shared types, codes and tables of the stepper sweep heading scanner.
// Used by the front, queue, back and top-level files; depends on nothing.
package sss_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] CFG_STEPS_NARROW = 2'd0;
	localparam logic [1:0] CFG_STEPS_HALF   = 2'd1;
	localparam logic [1:0] CFG_STEPS_FULL   = 2'd2;
	localparam logic [1:0] CFG_HEADING_THR  = 2'd3;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_SEEK  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_NARROW = 2'd0,
		MODE_HALF   = 2'd1,
		MODE_FULL   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic        fwd;
		logic        direct;
		mode_t       mode;
		logic [11:0] lim;
		logic [12:0] num;
	} job_t;

	function automatic logic [3:0] coil_of(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

	function automatic logic [8:0] range_of(input mode_t mode);
		logic [8:0] rng;
		case (mode)
			MODE_NARROW: rng = 9'd15;
			MODE_HALF:   rng = 9'd180;
			default:     rng = 9'd360;
		endcase
		return rng;
	endfunction

endpackage

// ===== design/sss_front.sv =====
// Front part: accepts items, holds configuration and sweep state, and
// turns each running tick into a job for the back part. Uses sss_pkg.
module sss_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [11:0]       cfg_data,
	input  logic              in_valid,
	input  logic [1:0]        in_req,
	input  logic [8:0]        in_compass,
	input  logic [8:0]        in_target,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output sss_pkg::job_t     job
);
	import sss_pkg::*;

	logic [11:0] steps_narrow_q;
	logic [11:0] steps_half_q;
	logic [11:0] steps_full_q;
	logic [8:0]  heading_thr_q;

	logic [12:0] step_count_q;
	logic        fwd_q;
	logic        running_q;
	mode_t       mode_q;
	logic        seeking_q;
	logic [8:0]  seek_target_q;

	logic        accept;
	req_t        req;
	logic [11:0] cur_lim;
	logic [11:0] new_lim;
	logic        wrap;
	logic        fwd_n;
	logic [12:0] cnt_n;
	logic [8:0]  err;
	mode_t       mode_n;
	logic        seeking_n;

	function automatic logic [11:0] limit_of(input mode_t m, input logic [11:0] ln,
			input logic [11:0] lh, input logic [11:0] lf);
		logic [11:0] l;
		case (m)
			MODE_NARROW: l = ln;
			MODE_HALF:   l = lh;
			default:     l = lf;
		endcase
		return l;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign req      = req_t'(in_req);

	always_comb begin
		cur_lim = limit_of(mode_q, steps_narrow_q, steps_half_q, steps_full_q);
		wrap    = step_count_q > {1'b0, cur_lim};
		fwd_n   = wrap ? !fwd_q : fwd_q;
		cnt_n   = (wrap ? 13'd0 : step_count_q) + 13'd1;
		err     = (seek_target_q > in_compass) ? seek_target_q - in_compass
			: in_compass - seek_target_q;
		mode_n    = mode_q;
		seeking_n = seeking_q;
		if (seeking_q) begin
			mode_n = MODE_FULL;
			if (err < heading_thr_q) begin
				mode_n    = MODE_NARROW;
				seeking_n = 1'b0;
			end
		end
		new_lim    = limit_of(mode_n, steps_narrow_q, steps_half_q, steps_full_q);
		job.fwd    = fwd_n;
		job.mode   = mode_n;
		job.lim    = new_lim;
		job.direct = (new_lim == 12'd0) || (!fwd_n && (cnt_n > {1'b0, new_lim}));
		job.num    = fwd_n ? cnt_n : ({1'b0, new_lim} - cnt_n);
	end

	assign push = accept && (req == REQ_TICK) && running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_narrow_q <= 12'd11;
			steps_half_q   <= 12'd128;
			steps_full_q   <= 12'd256;
			heading_thr_q  <= 9'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEPS_NARROW: steps_narrow_q <= cfg_data;
				CFG_STEPS_HALF:   steps_half_q   <= cfg_data;
				CFG_STEPS_FULL:   steps_full_q   <= cfg_data;
				CFG_HEADING_THR:  heading_thr_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q  <= 13'd0;
			fwd_q         <= 1'b1;
			running_q     <= 1'b1;
			mode_q        <= MODE_HALF;
			seeking_q     <= 1'b0;
			seek_target_q <= 9'd0;
		end else if (accept) begin
			case (req)
				REQ_START: begin
					running_q <= 1'b1;
					mode_q    <= MODE_HALF;
				end
				REQ_STOP: running_q <= 1'b0;
				REQ_SEEK: begin
					seeking_q     <= 1'b1;
					seek_target_q <= in_target;
				end
				REQ_TICK: begin
					if (running_q) begin
						step_count_q <= cnt_n;
						fwd_q        <= fwd_n;
						mode_q       <= mode_n;
						seeking_q    <= seeking_n;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/sss_queue.sv =====
// Short job queue between the front and back parts.
// Uses sss_pkg for the job type.
module sss_queue #(
	parameter int DEPTH = sss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sss_pkg::job_t din,
	input  logic          pop,
	output sss_pkg::job_t dout,
	output logic          full,
	output logic          empty
);
	import sss_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == FULL_CNT;
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sss_back.sv =====
// Back part: takes jobs, works out the sweep angle with a bit-serial
// divider, and emits the eight coil patterns of a step. Uses sss_pkg.
module sss_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  sss_pkg::job_t q_job,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,
	output logic          m_axis_tlast
);
	import sss_pkg::*;

	back_state_t state_q;
	back_state_t state_n;

	job_t        job_q;
	logic [21:0] rem_q;
	logic [21:0] div_q;
	logic [9:0]  quo_q;
	logic [3:0]  step_q;
	logic        sat_q;
	logic [8:0]  angle_q;
	logic [2:0]  phase_q;

	logic        out_valid_q;
	logic [3:0]  coil_q;
	logic        last_q;
	logic [8:0]  ang_out_q;
	logic        cw_q;

	logic        load_out;
	logic        div_done;
	logic        ge;
	logic [9:0]  quo_n;
	logic [8:0]  rng;
	logic [2:0]  idx;

	assign rng   = range_of(job_q.mode);
	assign ge    = rem_q >= div_q;
	assign quo_n = {quo_q[8:0], ge};
	assign idx   = job_q.fwd ? phase_q : ~phase_q;

	always_comb begin
		pop      = (state_q == BK_IDLE) && !q_empty;
		load_out = (state_q == BK_EMIT) && (!out_valid_q || m_axis_tready);
		div_done = (state_q == BK_DIV) && (step_q == 4'd9);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_n = q_job.direct ? BK_EMIT : BK_MUL;
				end
			end
			BK_MUL: state_n = BK_DIV;
			BK_DIV: begin
				if (div_done) begin
					state_n = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load_out && (phase_q == 3'd7)) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			phase_q     <= 3'd0;
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_MUL) begin
				step_q <= 4'd0;
			end else if (state_q == BK_DIV) begin
				step_q <= step_q + 4'd1;
			end
			if (pop) begin
				phase_q <= 3'd0;
			end else if (load_out) begin
				phase_q <= phase_q + 3'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q   <= q_job;
			angle_q <= q_job.fwd ? range_of(q_job.mode) : 9'd0;
		end
		if (state_q == BK_MUL) begin
			rem_q <= 22'(job_q.num * rng);
			div_q <= {1'b0, job_q.lim, 9'd0};
			quo_q <= 10'd0;
		end
		if (state_q == BK_DIV) begin
			if (step_q == 4'd0) begin
				sat_q <= rem_q >= {job_q.lim, 10'd0};
			end
			if (ge) begin
				rem_q <= rem_q - div_q;
			end
			div_q <= div_q >> 1;
			quo_q <= quo_n;
			if (div_done) begin
				angle_q <= (sat_q || (quo_n > {1'b0, rng})) ? rng : quo_n[8:0];
			end
		end
		if (load_out) begin
			coil_q    <= coil_of(idx);
			last_q    <= phase_q == 3'd7;
			ang_out_q <= angle_q;
			cw_q      <= job_q.fwd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {2'b00, cw_q, ang_out_q, coil_q};

endmodule

// ===== design/stepper_sweep_heading_scanner.sv =====
// Stepper sweep heading scanner: drives a four-coil stepper in a half-step
// back-and-forth sweep and narrows the sweep once a target heading is found.
//
// Input channel s_axis: tuser carries the request kind (tick, start, stop,
// seek); tdata carries compass_heading in [8:0] and target_heading in
// [17:9]. Start, stop and seek items update state and give no output.
// A tick while running gives eight output items on m_axis, one coil
// pattern each, with tlast on the eighth.
// Output channel m_axis: tdata holds coil_pattern [3:0], angle_degrees
// [12:4] and clockwise [13]; tlast is the last phase of the step.
// The front takes one item per cycle while the job queue has room. Each
// tick job passes through the back's fetch, multiply, bit-serial angle
// divider and emit states in turn; a tick whose angle needs no division
// goes from fetch straight to emit. The back fetches no new tick job until
// all eight patterns of the current step have been emitted.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at the next edge
// and are to be made only while the block is idle; it does not enforce this.
// Reset clears the queue and output, restores default limits, running on
// and a 180 degree clockwise sweep. A stalled receiver holds the output
// item; the back then waits, the queue fills and s_axis_tready drops.
module stepper_sweep_heading_scanner #(
	parameter int QUEUE_DEPTH = sss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // compass_heading, target_heading
	input  logic [1:0]  s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // coil_pattern, angle_degrees, clockwise
	output logic        m_axis_tlast    // last_phase
);
	import sss_pkg::*;

	job_t front_job;
	job_t queue_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	sss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_req     (s_axis_tuser),
		.in_compass (s_axis_tdata[8:0]),
		.in_target  (s_axis_tdata[17:9]),
		.q_full     (q_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.job        (front_job)
	);

	sss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_job),
		.pop    (pop),
		.dout   (queue_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	sss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (queue_job),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== design/sss_checker.sv =====
// Port-level checks of the stepper sweep heading scanner output stream.
// Bound to the top level; depends on its port list only.
module sss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	logic       out_acc;
	logic [2:0] phase_q;
	logic       cw_q;
	logic [8:0] ang_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 3'd0;
			cw_q    <= 1'b0;
			ang_q   <= 9'd0;
		end else if (out_acc) begin
			phase_q <= phase_q + 3'd1;
			cw_q    <= m_axis_tdata[13];
			ang_q   <= m_axis_tdata[12:4];
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	a_last_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (m_axis_tlast == (phase_q == 3'd7)))
		else $error("tlast not on the eighth pattern of a step");

	a_coil_half_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($countones(m_axis_tdata[3:0]) == 1 ||
			$countones(m_axis_tdata[3:0]) == 2))
		else $error("coil pattern is not a half-step pattern");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[12:4] <= 9'd360))
		else $error("angle beyond sweep range");

	a_step_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (phase_q != 3'd0) |->
			(m_axis_tdata[13] == cw_q && m_axis_tdata[12:4] == ang_q))
		else $error("direction or angle changed within a step");

endmodule

bind stepper_sweep_heading_scanner sss_checker u_sss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/sweep_step_checker.sv =====
// Checker for the stepper sweep heading scanner: follows register writes and
// accepted request items, predicts each step's eight coil items and compares.
// Depends on sss_pkg for the request, sweep mode and register codes.
module sweep_step_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // compass_heading, target_heading
	input  logic [1:0]  s_axis_tuser,   // req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // coil_pattern, angle_degrees, clockwise
	input  logic        m_axis_tlast,   // last_phase
	output int          pending,
	output int          checked,
	output int          fail_count
);
	import sss_pkg::*;

	// half-step coil table, entry 0 in the lowest nibble
	localparam logic [31:0] COIL_SEQUENCE = 32'h98C4_6231;

	typedef struct packed {
		logic [3:0] coil;
		logic       last;
		logic [8:0] angle;
		logic       cw;
	} coil_step_t;

	logic [11:0] lim_narrow, lim_half, lim_full;
	logic [8:0]  found_window;
	logic [12:0] step_cnt;
	logic        sweep_fwd, motor_on, seek_on;
	mode_t       sweep;
	logic [8:0]  seek_heading;
	coil_step_t  expected_coils[$];
	int          n_checked, n_fail;

	function automatic int unsigned limit_of_sweep();
		case (sweep)
			MODE_NARROW: return lim_narrow;
			MODE_HALF:   return lim_half;
			default:     return lim_full;
		endcase
	endfunction

	function automatic int unsigned span_of_sweep();
		case (sweep)
			MODE_NARROW: return 15;
			MODE_HALF:   return 180;
			default:     return 360;
		endcase
	endfunction

	function automatic logic [8:0] sweep_angle();
		int unsigned lim, span, num, a;
		lim = limit_of_sweep();
		span = span_of_sweep();
		if (lim == 0)
			return sweep_fwd ? span[8:0] : 9'd0;
		if (sweep_fwd) begin
			num = step_cnt;
		end else begin
			// past the limit in reverse: pinned at zero
			if (step_cnt > lim)
				return 9'd0;
			num = lim - step_cnt;
		end
		a = num * span / lim;
		if (a > span)
			a = span;
		return a[8:0];
	endfunction

	task automatic apply_request(input req_t kind, input logic [8:0] compass,
			input logic [8:0] target);
		logic [8:0] err;
		logic [8:0] ang;
		coil_step_t pat;
		int         k;
		case (kind)
			REQ_START: begin
				motor_on = 1'b1;
				sweep = MODE_HALF;
			end
			REQ_STOP: motor_on = 1'b0;
			REQ_SEEK: begin
				seek_on = 1'b1;
				seek_heading = target;
			end
			default: if (motor_on) begin
				if (step_cnt > limit_of_sweep()) begin
					step_cnt = '0;
					sweep_fwd = !sweep_fwd;
				end
				step_cnt = step_cnt + 13'd1;
				if (seek_on) begin
					sweep = MODE_FULL;
					// plain difference, no wrap at 360
					err = seek_heading > compass ? seek_heading - compass
						: compass - seek_heading;
					if (err < found_window) begin
						sweep = MODE_NARROW;
						seek_on = 1'b0;
					end
				end
				ang = sweep_angle();
				for (k = 0; k < 8; k++) begin
					pat.coil = COIL_SEQUENCE[(sweep_fwd ? k : 7 - k) * 4 +: 4];
					pat.last = (k == 7);
					pat.angle = ang;
					pat.cw = sweep_fwd;
					expected_coils.push_back(pat);
				end
			end
		endcase
	endtask

	task automatic check_coil_item();
		coil_step_t want;
		if (expected_coils.size() == 0) begin
			$error("coil item with no step outstanding: tdata %h tlast %b",
				m_axis_tdata, m_axis_tlast);
			n_fail++;
		end else begin
			want = expected_coils.pop_front();
			n_checked++;
			if (m_axis_tdata[3:0] !== want.coil) begin
				$error("coil_pattern: expected %h, got %h", want.coil, m_axis_tdata[3:0]);
				n_fail++;
			end
			if (m_axis_tlast !== want.last) begin
				$error("last_phase: expected %b, got %b", want.last, m_axis_tlast);
				n_fail++;
			end
			if (m_axis_tdata[12:4] !== want.angle) begin
				$error("angle_degrees: expected %0d, got %0d", want.angle,
					m_axis_tdata[12:4]);
				n_fail++;
			end
			if (m_axis_tdata[13] !== want.cw) begin
				$error("clockwise: expected %b, got %b", want.cw, m_axis_tdata[13]);
				n_fail++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_narrow = 12'd11;
			lim_half = 12'd128;
			lim_full = 12'd256;
			found_window = 9'd5;
			step_cnt = '0;
			sweep_fwd = 1'b1;
			motor_on = 1'b1;
			sweep = MODE_HALF;
			seek_on = 1'b0;
			seek_heading = '0;
			expected_coils.delete();
			n_checked = 0;
			n_fail = 0;
			pending <= 0;
			checked <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_coil_item();
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEPS_NARROW: lim_narrow = cfg_data;
					CFG_STEPS_HALF:   lim_half = cfg_data;
					CFG_STEPS_FULL:   lim_full = cfg_data;
					CFG_HEADING_THR:  found_window = cfg_data[8:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_request(req_t'(s_axis_tuser), s_axis_tdata[8:0], s_axis_tdata[17:9]);
			pending <= expected_coils.size();
			checked <= n_checked;
			fail_count <= n_fail;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the stepper sweep heading scanner bench: clock, reset, register
// programming, request stimulus with bursts and receiver stalls, verdict.
// Depends on sss_pkg, the scanner RTL and sweep_step_checker.
module testbench;
	import sss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // compass_heading, target_heading
	logic [1:0]  s_axis_tuser;   // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // coil_pattern, angle_degrees, clockwise
	logic        m_axis_tlast;   // last_phase
	int          pending, checked, fail_count;

	rx_style_t   stall_style;
	logic        hold_arm;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          stall_phase = 0;
	int          cycle_count = 0;

	bit          gaps_on;
	int          burst_left = 0;
	int          sent_items = 0;
	int          sent_ticks = 0;
	logic [8:0]  last_target = '0;

	stepper_sweep_heading_scanner dut (.*);

	sweep_step_checker checker_i (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: one long hold-off when armed, otherwise the current stall style
	always @(posedge clk) begin
		stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
		if (hold_arm && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (stall_style)
				RX_ALWAYS:   m_axis_tready <= 1'b1;
				RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: m_axis_tready <= (stall_phase > 1);
				default:     m_axis_tready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	task automatic send_item(input req_t kind, input logic [8:0] compass,
			input logic [8:0] target);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {6'd0, target, compass};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		sent_items++;
		if (kind == REQ_TICK)
			sent_ticks++;
	endtask

	// hold the sender until every predicted item is out, then let the block settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input logic [11:0] narrow, half, full, window);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEPS_NARROW;
		cfg_data <= narrow;
		@(posedge clk);
		cfg_index <= CFG_STEPS_HALF;
		cfg_data <= half;
		@(posedge clk);
		cfg_index <= CFG_STEPS_FULL;
		cfg_data <= full;
		@(posedge clk);
		cfg_index <= CFG_HEADING_THR;
		cfg_data <= window;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_items(input int count);
		int         i, pick, near;
		logic [8:0] compass, target;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			target = ($urandom_range(0, 7) == 0) ? 9'd359 : 9'($urandom_range(0, 359));
			near = int'(last_target) + int'($urandom_range(0, 24)) - 12;
			if (near < 0)
				near = 0;
			if (near > 359)
				near = 359;
			compass = $urandom_range(0, 1) ? 9'(near) : 9'($urandom_range(0, 359));
			if (pick < 66) begin
				send_item(REQ_TICK, compass, target);
			end else if (pick < 78) begin
				last_target = target;
				send_item(REQ_SEEK, compass, target);
			end else if (pick < 88) begin
				send_item(REQ_START, compass, target);
			end else if (pick < 94) begin
				send_item(REQ_STOP, compass, target);
			end else begin
				send_item(REQ_TICK, 9'($urandom_range(0, 359)), target);
			end
		end
	endtask

	task automatic run_phase(input logic [11:0] narrow, half, full, window,
			input bit gaps, input rx_style_t rx, input bit long_hold, input int count);
		wait_drained();
		program_registers(narrow, half, full, window);
		gaps_on = gaps;
		stall_style <= rx;
		if (long_hold)
			hold_arm <= 1'b1;
		send_random_items(count / 2);
		wait_drained();
		send_random_items(count - count / 2);
	endtask

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= CFG_STEPS_NARROW;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= REQ_TICK;
		stall_style <= RX_RANDOM;
		hold_arm <= 1'b0;
		gaps_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: heading extremes, seek found and not found,
		// tick while stopped, start back to the half sweep, narrow wrap
		send_item(REQ_TICK, 9'd0, 9'd359);
		send_item(REQ_TICK, 9'd359, 9'd0);
		send_item(REQ_SEEK, 9'd0, 9'd359);
		send_item(REQ_TICK, 9'd0, 9'd0);
		send_item(REQ_TICK, 9'd356, 9'd0);
		send_item(REQ_STOP, 9'd0, 9'd0);
		send_item(REQ_TICK, 9'd100, 9'd0);
		send_item(REQ_START, 9'd0, 9'd0);
		send_item(REQ_SEEK, 9'd359, 9'd0);
		send_item(REQ_TICK, 9'd359, 9'd0);
		send_item(REQ_TICK, 9'd4, 9'd0);
		repeat (8)
			send_item(REQ_TICK, 9'd200, 9'($urandom_range(0, 359)));
		send_item(REQ_TICK, 9'd359, 9'd359);

		run_phase(12'd1, 12'd2, 12'd3, 12'd0, 1'b1, RX_PERIODIC, 1'b0, 62);
		run_phase(12'd4095, 12'd4095, 12'd4095, 12'd359, 1'b0, RX_SPARSE, 1'b0, 62);
		run_phase(12'd0, 12'd5, 12'd0, 12'd20, 1'b1, RX_RANDOM, 1'b0, 62);
		run_phase(12'd3, 12'd7, 12'd12, 12'd30, 1'b0, RX_ALWAYS, 1'b1, 62);
		run_phase(12'd2, 12'd9, 12'd5, 12'hE14, 1'b1, RX_RANDOM, 1'b0, 62);
		wait_drained();

		$display("Run covered %0d request items (%0d ticks) and %0d coil items checked,",
			sent_items, sent_ticks, checked);
		$display("across six register settings from zero and one up to 4095 steps.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
